>>> rtl/ssbp_pkg.sv
// Package with shared types and constants for the SysEx seven-bit block packer.
`timescale 1ns / 1ps
`default_nettype none

package ssbp_pkg;

    // Block byte counter width; covers blocks of up to 63 bytes.
    localparam int COUNT_W             = 6;
    localparam int BYTES_PER_BLOCK_DEF = 32;

    // One word can cause at most seven stream bytes; the list holds eight.
    localparam int LIST_DEPTH = 8;
    localparam int LIST_IDX_W = 3;

    localparam logic [7:0] HDR_START  = 8'hf0;
    localparam logic [7:0] HDR_ID0    = 8'h00;
    localparam logic [7:0] HDR_ID1    = 8'h20;
    localparam logic [7:0] HDR_ID2    = 8'h29;
    localparam logic [7:0] HDR_DEV    = 8'h00;
    localparam logic [7:0] TYPE_PLAIN = 8'h72;
    localparam logic [7:0] TYPE_FINAL = 8'h73;
    localparam logic [7:0] END_BYTE   = 8'hf7;
    localparam logic [7:0] PAD_BYTE   = 8'hff;

    typedef struct packed {
        logic [7:0] value;
        logic       eob;
    } entry_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [6:0]         bits;
        logic [2:0]         nbits;
    } pack_state_t;

endpackage

`default_nettype wire

>>> rtl/ssbp_pack.sv
// Combinational packer: builds the stream bytes for one word and the next accumulator state.
`timescale 1ns / 1ps
`default_nettype none

module ssbp_pack #(
    parameter int BYTES_PER_BLOCK = ssbp_pkg::BYTES_PER_BLOCK_DEF
) (
    input  ssbp_pkg::pack_state_t              state,
    input  logic [7:0]                         data_byte,
    input  logic                               present,
    input  logic                               block_kind,
    output ssbp_pkg::entry_t                   entries [ssbp_pkg::LIST_DEPTH],
    output logic [ssbp_pkg::LIST_IDX_W-1:0]    last_idx,
    output ssbp_pkg::pack_state_t              state_next
);

    logic [7:0]                     byte_val;
    logic [14:0]                    acc;
    logic [14:0]                    shifted;
    logic [2:0]                     n;
    logic [2:0]                     new_n;
    logic [6:0]                     new_bits;
    logic [7:0]                     mask;
    logic [6:0]                     leftover;
    logic [3:0]                     k;
    logic [ssbp_pkg::COUNT_W-1:0]   cnt1;

    always_comb
    begin
        for (int i = 0; i < ssbp_pkg::LIST_DEPTH; i++)
        begin
            entries[i] = '{value: 8'h00, eob: 1'b0};
        end
        k = 4'd0;

        if (state.count == '0)
        begin
            entries[0].value = ssbp_pkg::HDR_START;
            entries[1].value = ssbp_pkg::HDR_ID0;
            entries[2].value = ssbp_pkg::HDR_ID1;
            entries[3].value = ssbp_pkg::HDR_ID2;
            entries[4].value = ssbp_pkg::HDR_DEV;
            entries[5].value = block_kind ? ssbp_pkg::TYPE_FINAL : ssbp_pkg::TYPE_PLAIN;
            k = 4'd6;
        end

        byte_val = present ? data_byte : ssbp_pkg::PAD_BYTE;
        acc      = {state.bits, byte_val};
        n        = state.nbits;

        // The oldest seven of the n+8 accumulated bits always leave first.
        shifted = acc >> ({1'b0, n} + 4'd1);
        entries[k[2:0]].value = {1'b0, shifted[6:0]};
        k = k + 4'd1;

        mask = 8'h00;
        if (n == 3'd6)
        begin
            // Fourteen bits make exactly two bytes.
            entries[k[2:0]].value = {1'b0, acc[6:0]};
            k        = k + 4'd1;
            new_n    = 3'd0;
            new_bits = 7'h00;
        end
        else
        begin
            new_n    = n + 3'd1;
            mask     = (8'd1 << new_n) - 8'd1;
            new_bits = acc[6:0] & mask[6:0];
        end

        cnt1     = state.count + ssbp_pkg::COUNT_W'(1);
        leftover = new_bits << (3'd7 - new_n);

        if (cnt1 >= ssbp_pkg::COUNT_W'(BYTES_PER_BLOCK))
        begin
            if (new_n != 3'd0)
            begin
                entries[k[2:0]].value = {1'b0, leftover};
                k = k + 4'd1;
            end
            entries[k[2:0]].value = ssbp_pkg::END_BYTE;
            entries[k[2:0]].eob   = 1'b1;
            k = k + 4'd1;
            state_next = '{count: '0, bits: 7'h00, nbits: 3'd0};
        end
        else
        begin
            state_next = '{count: cnt1, bits: new_bits, nbits: new_n};
        end

        last_idx = 3'(k - 4'd1);
    end

endmodule

`default_nettype wire

>>> rtl/sysex_seven_bit_block_packer_core.sv
// Top level of the SysEx seven-bit block packer: input register, packer and output byte list.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | to core   | in_valid / in_ready   | data_byte[7:0], present, block_kind
//  out     | from core | out_valid / out_ready | out_byte[7:0], end_of_run, end_of_block
//
// A word waits in the input register and is packed into a list of one to seven stream
// bytes when the list is empty or hands over its last byte; its first byte is offered in
// the next cycle. The list then sends one byte per cycle while out_ready is high (one or
// two mid-block, up to three for the last word, seven for the first word of a block).
// Reset empties both stages and starts a fresh block. An output stall holds the list and,
// with a word waiting, holds in_ready low.
`timescale 1ns / 1ps
`default_nettype none

module sysex_seven_bit_block_packer_core #(
    parameter int BYTES_PER_BLOCK = ssbp_pkg::BYTES_PER_BLOCK_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       present,
    input  logic       block_kind,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       end_of_run,
    output logic       end_of_block
);

    logic                                in_full_reg;
    logic [7:0]                          in_data_reg;
    logic                                in_present_reg;
    logic                                in_kind_reg;
    ssbp_pkg::pack_state_t               state_reg;
    logic                                list_valid_reg;
    ssbp_pkg::entry_t                    list_reg [ssbp_pkg::LIST_DEPTH];
    logic [ssbp_pkg::LIST_IDX_W-1:0]     last_reg;
    logic [ssbp_pkg::LIST_IDX_W-1:0]     idx_reg;

    ssbp_pkg::entry_t                    entries_next [ssbp_pkg::LIST_DEPTH];
    logic [ssbp_pkg::LIST_IDX_W-1:0]     last_next;
    ssbp_pkg::pack_state_t               state_next;

    logic in_fire;
    logic out_fire;
    logic out_done;
    logic move;

    ssbp_pack #(
        .BYTES_PER_BLOCK(BYTES_PER_BLOCK)
    ) u_pack (
        .state      (state_reg),
        .data_byte  (in_data_reg),
        .present    (in_present_reg),
        .block_kind (in_kind_reg),
        .entries    (entries_next),
        .last_idx   (last_next),
        .state_next (state_next)
    );

    // The input register can take a new word in the same cycle its waiting word moves on.
    assign in_ready  = !in_full_reg || move;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = list_valid_reg;
    assign out_fire  = out_valid && out_ready;
    assign out_done  = out_fire && (idx_reg == last_reg);
    // The waiting word enters the list once the list is empty or drains this cycle.
    assign move      = in_full_reg && (!list_valid_reg || out_done);

    assign out_byte     = list_reg[idx_reg].value;
    assign end_of_block = list_reg[idx_reg].eob;
    assign end_of_run   = (idx_reg == last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            list_valid_reg <= 1'b0;
            idx_reg        <= '0;
            last_reg       <= '0;
            state_reg      <= '{count: '0, bits: 7'h00, nbits: 3'd0};
        end
        else
        begin
            if (in_fire)
            begin
                in_full_reg <= 1'b1;
            end
            else if (move)
            begin
                in_full_reg <= 1'b0;
            end

            if (move)
            begin
                list_valid_reg <= 1'b1;
                idx_reg        <= '0;
                last_reg       <= last_next;
                state_reg      <= state_next;
            end
            else if (out_done)
            begin
                list_valid_reg <= 1'b0;
            end
            else if (out_fire)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_data_reg    <= data_byte;
            in_present_reg <= present;
            in_kind_reg    <= block_kind;
        end
        if (move)
        begin
            list_reg <= entries_next;
        end
    end

endmodule

`default_nettype wire
